// ===== rtl/core/bml_pkg.sv =====
// Shared types and constants for the bilinear map lookup core.
// No dependencies; imported by every module of the core.
`timescale 1ns / 1ps
`default_nettype none
package bml_pkg;

    localparam logic [1:0] OP_WR_X   = 2'd0;
    localparam logic [1:0] OP_WR_Y   = 2'd1;
    localparam logic [1:0] OP_WR_Z   = 2'd2;
    localparam logic [1:0] OP_QUERY  = 2'd3;

    localparam logic [1:0] CFG_X_COUNT = 2'd0;
    localparam logic [1:0] CFG_Y_COUNT = 2'd1;

    localparam int XV_W = 14;
    localparam int YV_W = 10;
    localparam int ZV_W = 16;

    typedef struct packed {
        logic [1:0]               op;
        logic [5:0]               entry_index;
        logic signed [ZV_W-1:0]   entry_value;
        logic [XV_W-1:0]          query_x;
        logic [YV_W-1:0]          query_y;
    } item_t;

endpackage
`default_nettype wire

// ===== rtl/core/bml_front.sv =====
// Front end: accepts command words and holds them in a two-entry queue.
// Depends on bml_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bml_front
    import bml_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [1:0]             op,
    input  wire logic [5:0]             entry_index,
    input  wire logic signed [ZV_W-1:0] entry_value,
    input  wire logic [XV_W-1:0]        query_x,
    input  wire logic [YV_W-1:0]        query_y,
    output logic                        item_valid,
    output item_t                       item,
    input  wire logic                   pop
);

    item_t       slot_reg [2];
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic [1:0]  count_reg, count_next;
    logic        push;
    logic        do_pop;

    assign busy       = (count_reg == 2'd2);
    assign push       = start && !busy;
    assign item_valid = (count_reg != 2'd0);
    assign do_pop     = pop && item_valid;
    assign item       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + {1'b0, push} - {1'b0, do_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= '{op: op, entry_index: entry_index,
                                      entry_value: entry_value,
                                      query_x: query_x, query_y: query_y};
        end
    end

endmodule
`default_nettype wire

// ===== rtl/core/bml_div.sv =====
// Serial signed-by-unsigned divider, one quotient bit per cycle, truncating.
// Depends on bml_pkg.
`timescale 1ns / 1ps
`default_nettype none
module bml_div
    import bml_pkg::*;
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 start,
    input  wire logic signed [31:0]   dividend,
    input  wire logic [XV_W-1:0]      divisor,
    output logic                      done,
    output logic signed [31:0]        quotient
);

    logic              run_reg, run_next;
    logic              done_reg, done_next;
    logic [4:0]        cnt_reg, cnt_next;
    logic [31:0]       mag_reg, mag_next;
    logic [XV_W:0]     rem_reg, rem_next;
    logic [XV_W-1:0]   dsr_reg, dsr_next;
    logic              neg_reg, neg_next;
    logic [XV_W:0]     trial;
    logic              fit;

    assign trial = {rem_reg[XV_W-1:0], mag_reg[31]};
    assign fit   = (trial >= {1'b0, dsr_reg});

    always_comb
    begin
        run_next  = run_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        neg_next  = neg_reg;
        if (start)
        begin
            run_next = 1'b1;
            cnt_next = 5'd0;
            neg_next = dividend[31];
            mag_next = dividend[31] ? 32'(-dividend) : 32'(dividend);
            rem_next = '0;
            dsr_next = divisor;
        end
        else if (run_reg)
        begin
            rem_next = fit ? (trial - {1'b0, dsr_reg}) : trial;
            mag_next = {mag_reg[30:0], fit};
            cnt_next = cnt_reg + 5'd1;
            if (cnt_reg == 5'd31)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else
        begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        neg_reg <= neg_next;
    end

    assign done     = done_reg;
    assign quotient = neg_reg ? -signed'(mag_reg) : signed'(mag_reg);

endmodule
`default_nettype wire

// ===== rtl/core/bml_back.sv =====
// Back end: axis and grid stores, bracket search, interpolation sequencer.
// Depends on bml_pkg and bml_div.
`timescale 1ns / 1ps
`default_nettype none
module bml_back
    import bml_pkg::*;
#(
    parameter int X_POINTS = 16,
    parameter int Y_POINTS = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic [4:0]             x_count,
    input  wire logic [2:0]             y_count,
    input  wire logic                   item_valid,
    input  wire item_t                  item,
    output logic                        pop,
    output logic                        result_valid,
    output logic signed [ZV_W-1:0]      z_value,
    output logic                        out_of_range,
    output logic                        is_query
);

    localparam int XW  = $clog2(X_POINTS);
    localparam int YW  = $clog2(Y_POINTS);
    localparam int GD  = X_POINTS * Y_POINTS;
    localparam int GW  = $clog2(GD);
    localparam int XNW = $clog2(X_POINTS + 1);
    localparam int YNW = $clog2(Y_POINTS + 1);

    localparam logic [1:0] LI_Y0 = 2'd0;
    localparam logic [1:0] LI_Y1 = 2'd1;
    localparam logic [1:0] LI_X  = 2'd2;

    typedef enum logic [11:0] {
        S_IDLE = 12'b0000_0000_0001,
        S_XRD  = 12'b0000_0000_0010,
        S_XCHK = 12'b0000_0000_0100,
        S_YRD  = 12'b0000_0000_1000,
        S_YCHK = 12'b0000_0001_0000,
        S_GRD  = 12'b0000_0010_0000,
        S_GCAP = 12'b0000_0100_0000,
        S_SET  = 12'b0000_1000_0000,
        S_MUL  = 12'b0001_0000_0000,
        S_DST  = 12'b0010_0000_0000,
        S_DIV  = 12'b0100_0000_0000,
        S_ADD  = 12'b1000_0000_0000
    } state_t;

    state_t                 state_reg, state_next;
    item_t                  it_reg, it_next;
    logic [XW-1:0]          xk_reg, xk_next;
    logic [YW-1:0]          yk_reg, yk_next;
    logic [XV_W-1:0]        prev_reg, prev_next;
    logic [XW-1:0]          xlo_reg, xlo_next, xhi_reg, xhi_next;
    logic [YW-1:0]          ylo_reg, ylo_next, yhi_reg, yhi_next;
    logic [XV_W-1:0]        x1_reg, x1_next, x2_reg, x2_next;
    logic [YV_W-1:0]        y1_reg, y1_next, y2_reg, y2_next;
    logic [1:0]             gcnt_reg, gcnt_next;
    logic signed [ZV_W-1:0] zc_reg [4];
    logic signed [ZV_W-1:0] zc_next [4];
    logic signed [ZV_W-1:0] za_reg, za_next, zb_reg, zb_next;
    logic [1:0]             li_reg, li_next;
    logic signed [31:0]     prod_reg, prod_next;
    logic [XV_W-1:0]        den_reg, den_next;
    logic signed [ZV_W-1:0] quot_reg, quot_next;
    logic                   rv_reg, rv_next;
    logic signed [ZV_W-1:0] z_reg, z_next;
    logic                   oor_reg, oor_next;
    logic                   isq_reg, isq_next;

    logic [XV_W-1:0]        x_mem [X_POINTS];
    logic [YV_W-1:0]        y_mem [Y_POINTS];
    logic signed [ZV_W-1:0] g_mem [GD];
    logic [XV_W-1:0]        x_rd_reg;
    logic [YV_W-1:0]        y_rd_reg;
    logic signed [ZV_W-1:0] g_rd_reg;
    logic [GW-1:0]          g_raddr;
    logic                   x_we, y_we, g_we;

    logic [XNW-1:0]         nx;
    logic [YNW-1:0]         ny;
    logic                   xeq, yeq;
    logic [XV_W-1:0]        lp, lpa, lpb;
    logic signed [ZV_W-1:0] la, lb;
    logic signed [16:0]     dz;
    logic signed [XV_W:0]   dp;
    logic signed [ZV_W-1:0] lres;
    logic                   div_start, div_done;
    logic signed [31:0]     div_q;

    assign nx = (32'(x_count) > X_POINTS) ? XNW'(X_POINTS) : XNW'(x_count);
    assign ny = (32'(y_count) > Y_POINTS) ? YNW'(Y_POINTS) : YNW'(y_count);
    assign xeq = (xlo_reg == xhi_reg);
    assign yeq = (ylo_reg == yhi_reg);

    // stores: one write port fed straight from the queue head, one read port
    assign x_we = pop && item.op == OP_WR_X && 32'(item.entry_index) < X_POINTS;
    assign y_we = pop && item.op == OP_WR_Y && 32'(item.entry_index) < Y_POINTS;
    assign g_we = pop && item.op == OP_WR_Z && 32'(item.entry_index) < GD;

    assign g_raddr = GW'(32'(gcnt_reg[1] ? yhi_reg : ylo_reg) * X_POINTS
                         + 32'(gcnt_reg[0] ? xhi_reg : xlo_reg));

    always_ff @(posedge clk)
    begin
        if (x_we)
            x_mem[XW'(item.entry_index)] <= item.entry_value[XV_W-1:0];
        x_rd_reg <= x_mem[xk_reg];
    end

    always_ff @(posedge clk)
    begin
        if (y_we)
            y_mem[YW'(item.entry_index)] <= item.entry_value[YV_W-1:0];
        y_rd_reg <= y_mem[yk_reg];
    end

    always_ff @(posedge clk)
    begin
        if (g_we)
            g_mem[GW'(item.entry_index)] <= item.entry_value;
        g_rd_reg <= g_mem[g_raddr];
    end

    // lerp operand select: y pass on columns a and b, then x pass
    always_comb
    begin
        case (li_reg)
            LI_Y0:
            begin
                lp = XV_W'(it_reg.query_y); lpa = XV_W'(y1_reg); lpb = XV_W'(y2_reg);
                la = zc_reg[0]; lb = zc_reg[2];
            end
            LI_Y1:
            begin
                lp = XV_W'(it_reg.query_y); lpa = XV_W'(y1_reg); lpb = XV_W'(y2_reg);
                la = zc_reg[1]; lb = zc_reg[3];
            end
            default:
            begin
                lp = it_reg.query_x; lpa = x1_reg; lpb = x2_reg;
                la = za_reg; lb = zb_reg;
            end
        endcase
        dz   = 17'(lb) - 17'(la);
        dp   = signed'({1'b0, lp}) - signed'({1'b0, lpa});
        lres = la + quot_reg;
    end

    bml_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (prod_reg),
        .divisor  (den_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_comb
    begin
        state_next = state_reg;
        it_next    = it_reg;
        xk_next    = xk_reg;
        yk_next    = yk_reg;
        prev_next  = prev_reg;
        xlo_next   = xlo_reg;
        xhi_next   = xhi_reg;
        ylo_next   = ylo_reg;
        yhi_next   = yhi_reg;
        x1_next    = x1_reg;
        x2_next    = x2_reg;
        y1_next    = y1_reg;
        y2_next    = y2_reg;
        gcnt_next  = gcnt_reg;
        zc_next    = zc_reg;
        za_next    = za_reg;
        zb_next    = zb_reg;
        li_next    = li_reg;
        prod_next  = prod_reg;
        den_next   = den_reg;
        quot_next  = quot_reg;
        rv_next    = 1'b0;
        z_next     = z_reg;
        oor_next   = oor_reg;
        isq_next   = isq_reg;
        pop        = 1'b0;
        div_start  = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    pop     = 1'b1;
                    it_next = item;
                    case (item.op)
                        OP_WR_X, OP_WR_Y, OP_WR_Z:
                        begin
                            rv_next  = 1'b1;
                            z_next   = '0;
                            oor_next = 1'b0;
                            isq_next = 1'b0;
                        end
                        default:
                        begin
                            if (32'(nx) < 2 || 32'(ny) < 2)
                            begin
                                rv_next  = 1'b1;
                                z_next   = '0;
                                oor_next = 1'b1;
                                isq_next = 1'b1;
                            end
                            else
                            begin
                                xk_next    = '0;
                                state_next = S_XRD;
                            end
                        end
                    endcase
                end
            end
            S_XRD:
                state_next = S_XCHK;
            S_XCHK:
            begin
                // pair (k-1,k): strictly between, then exact hit on entry k
                if (xk_reg != '0 && it_reg.query_x > prev_reg
                    && it_reg.query_x < x_rd_reg)
                begin
                    xlo_next = xk_reg - XW'(1); xhi_next = xk_reg;
                    x1_next = prev_reg; x2_next = x_rd_reg;
                    yk_next = '0; state_next = S_YRD;
                end
                else if (it_reg.query_x == x_rd_reg)
                begin
                    xlo_next = xk_reg; xhi_next = xk_reg;
                    x1_next = x_rd_reg; x2_next = x_rd_reg;
                    yk_next = '0; state_next = S_YRD;
                end
                else if (32'(xk_reg) == 32'(nx) - 1)
                begin
                    rv_next = 1'b1; z_next = '0; oor_next = 1'b1; isq_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    prev_next = x_rd_reg;
                    xk_next = xk_reg + XW'(1);
                    state_next = S_XRD;
                end
            end
            S_YRD:
                state_next = S_YCHK;
            S_YCHK:
            begin
                if (yk_reg != '0 && XV_W'(it_reg.query_y) > prev_reg
                    && it_reg.query_y < y_rd_reg)
                begin
                    ylo_next = yk_reg - YW'(1); yhi_next = yk_reg;
                    y1_next = prev_reg[YV_W-1:0]; y2_next = y_rd_reg;
                    gcnt_next = 2'd0; state_next = S_GRD;
                end
                else if (it_reg.query_y == y_rd_reg)
                begin
                    ylo_next = yk_reg; yhi_next = yk_reg;
                    y1_next = y_rd_reg; y2_next = y_rd_reg;
                    gcnt_next = 2'd0; state_next = S_GRD;
                end
                else if (32'(yk_reg) == 32'(ny) - 1)
                begin
                    rv_next = 1'b1; z_next = '0; oor_next = 1'b1; isq_next = 1'b1;
                    state_next = S_IDLE;
                end
                else
                begin
                    prev_next = XV_W'(y_rd_reg);
                    yk_next = yk_reg + YW'(1);
                    state_next = S_YRD;
                end
            end
            S_GRD:
                state_next = S_GCAP;
            S_GCAP:
            begin
                // corners in order z11, z21, z12, z22
                zc_next[gcnt_reg] = g_rd_reg;
                gcnt_next = gcnt_reg + 2'd1;
                state_next = (gcnt_reg == 2'd3) ? S_SET : S_GRD;
            end
            S_SET:
            begin
                if (xeq && yeq)
                begin
                    rv_next = 1'b1; z_next = zc_reg[0]; oor_next = 1'b0; isq_next = 1'b1;
                    state_next = S_IDLE;
                end
                else if (yeq)
                begin
                    za_next = zc_reg[0]; zb_next = zc_reg[1];
                    li_next = LI_X; state_next = S_MUL;
                end
                else
                begin
                    li_next = LI_Y0; state_next = S_MUL;
                end
            end
            S_MUL:
            begin
                prod_next  = 32'(dz) * 32'(dp);
                den_next   = lpb - lpa;
                state_next = S_DST;
            end
            S_DST:
            begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    quot_next  = div_q[ZV_W-1:0];
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                if (li_reg == LI_Y0 && !xeq)
                begin
                    za_next = lres; li_next = LI_Y1; state_next = S_MUL;
                end
                else if (li_reg == LI_Y1)
                begin
                    zb_next = lres; li_next = LI_X; state_next = S_MUL;
                end
                else
                begin
                    rv_next = 1'b1; z_next = lres; oor_next = 1'b0; isq_next = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            rv_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rv_reg    <= rv_next;
        end
    end

    always_ff @(posedge clk)
    begin
        it_reg   <= it_next;
        xk_reg   <= xk_next;
        yk_reg   <= yk_next;
        prev_reg <= prev_next;
        xlo_reg  <= xlo_next;
        xhi_reg  <= xhi_next;
        ylo_reg  <= ylo_next;
        yhi_reg  <= yhi_next;
        x1_reg   <= x1_next;
        x2_reg   <= x2_next;
        y1_reg   <= y1_next;
        y2_reg   <= y2_next;
        gcnt_reg <= gcnt_next;
        zc_reg   <= zc_next;
        za_reg   <= za_next;
        zb_reg   <= zb_next;
        li_reg   <= li_next;
        prod_reg <= prod_next;
        den_reg  <= den_next;
        quot_reg <= quot_next;
        z_reg    <= z_next;
        oor_reg  <= oor_next;
        isq_reg  <= isq_next;
    end

    assign result_valid = rv_reg;
    assign z_value      = z_reg;
    assign out_of_range = oor_reg;
    assign is_query     = isq_reg;

`ifndef ASSERT_OFF
    a_pop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> state_reg == S_IDLE)
        else $error("queue popped while a query is in flight");
    a_add_after_div: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_ADD |-> $past(div_done))
        else $error("lerp add entered without a divider result");
    a_ack_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg && !isq_reg |-> z_reg == '0 && !oor_reg)
        else $error("write acknowledge carries data");
    a_oor_query: assert property (@(posedge clk) disable iff (!rst_n)
        rv_reg && oor_reg |-> isq_reg && z_reg == '0)
        else $error("range flag on a non-query word");
`endif

endmodule
`default_nettype wire

// ===== rtl/core/bilinear_map_lookup_core.sv =====
// Bilinear map lookup core: config registers, command queue and lookup engine.
// Depends on bml_pkg, bml_front and bml_back.
//
// Each write to the axis and grid stores is done by the lookup engine from idle.
// A query scans the x axis then the y axis, reading and checking each breakpoint
// visited in turn, reads the four grid corners one at a time, then runs zero,
// one or three interpolations, each a multiply and a 32-step serial division.
// An out-of-range query ends as soon as its scan fails, and at once when a
// count is below two.
// A two-word command queue lets start be taken while the engine works; busy
// is high only when the queue is full. Every word gives exactly one result,
// shown for one cycle with result_valid; the receiver has no way to stall it.
// Axis and grid entries must be written before a query reads them.
`timescale 1ns / 1ps
`default_nettype none
module bilinear_map_lookup_core
    import bml_pkg::*;
#(
    parameter int X_POINTS = 16,
    parameter int Y_POINTS = 4
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [1:0]             op,
    input  wire logic [5:0]             entry_index,
    input  wire logic signed [ZV_W-1:0] entry_value,
    input  wire logic [XV_W-1:0]        query_x,
    input  wire logic [YV_W-1:0]        query_y,
    output logic                        result_valid,
    output logic signed [ZV_W-1:0]      z_value,
    output logic                        out_of_range,
    output logic                        is_query,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [1:0]             cfg_index,
    input  wire logic [4:0]             cfg_data
);

    logic [4:0] x_count_reg, x_count_next;
    logic [2:0] y_count_reg, y_count_next;
    logic       item_valid;
    item_t      item;
    logic       pop;

    assign cfg_ready = 1'b1;

    always_comb
    begin
        x_count_next = x_count_reg;
        y_count_next = y_count_reg;
        if (cfg_valid)
        begin
            case (cfg_index)
                CFG_X_COUNT: x_count_next = cfg_data;
                CFG_Y_COUNT: y_count_next = cfg_data[2:0];
                default:     ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_count_reg <= 5'd15;
            y_count_reg <= 3'd3;
        end
        else
        begin
            x_count_reg <= x_count_next;
            y_count_reg <= y_count_next;
        end
    end

    bml_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .op          (op),
        .entry_index (entry_index),
        .entry_value (entry_value),
        .query_x     (query_x),
        .query_y     (query_y),
        .item_valid  (item_valid),
        .item        (item),
        .pop         (pop)
    );

    bml_back #(
        .X_POINTS (X_POINTS),
        .Y_POINTS (Y_POINTS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .x_count      (x_count_reg),
        .y_count      (y_count_reg),
        .item_valid   (item_valid),
        .item         (item),
        .pop          (pop),
        .result_valid (result_valid),
        .z_value      (z_value),
        .out_of_range (out_of_range),
        .is_query     (is_query)
    );

endmodule
`default_nettype wire
